/* rtl/fps_pkg.sv */
// ----------------------------------------------------------------------------
// fps_pkg
// Shared widths, opcodes, sequencer states and control structs of the
// Fenwick prefix-sum engine.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int IDX_W  = 10;
    localparam int DATA_W = 32;
    localparam int SIZE_W = 11;

    localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 11'd1024;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } t_state;

    // sequencer -> walk unit
    typedef struct packed {
        logic load;      // capture a new item
        logic walk;      // run one walk step
        logic clr;       // write one zero cell of the clearing pass
        logic out_load;  // move the prefix sum to the output register
    } t_ctl;

    // walk unit -> sequencer
    typedef struct packed {
        logic cont;      // another cell lies on the walk
        logic clr_last;  // clearing pass is at its final cell
        logic is_query;  // item under way is a query
    } t_sts;

endpackage

/* rtl/fps_in_if.sv */
// ----------------------------------------------------------------------------
// fps_in_if
// Input item channel: op, index and delta with valid/ready.
// ----------------------------------------------------------------------------
interface fps_in_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic        [fps_pkg::IDX_W-1:0]  index;
    logic signed [fps_pkg::DATA_W-1:0] delta;

    modport source (output valid, output op, output index, output delta, input ready);
    modport sink   (input valid, input op, input index, input delta, output ready);
endinterface

/* rtl/fps_out_if.sv */
// ----------------------------------------------------------------------------
// fps_out_if
// Result item channel: prefix_sum with valid/ready.
// ----------------------------------------------------------------------------
interface fps_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [fps_pkg::DATA_W-1:0] prefix_sum;

    modport source (output valid, output prefix_sum, input ready);
    modport sink   (input valid, input prefix_sum, output ready);
endinterface

/* rtl/fps_cfg_if.sv */
// ----------------------------------------------------------------------------
// fps_cfg_if
// Configuration write channel carrying the active_size register.
// ----------------------------------------------------------------------------
interface fps_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [fps_pkg::SIZE_W-1:0]  active_size;

    modport source (output valid, output active_size, input ready);
    modport sink   (input valid, input active_size, output ready);
endinterface

/* rtl/fps_ram.sv */
// ----------------------------------------------------------------------------
// fps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fps_walk.sv */
// ----------------------------------------------------------------------------
// fps_walk
// Walk unit: position register, lowest-set-bit step and the one shared
// 32-bit adder used for both cell updates and prefix accumulation.
// ----------------------------------------------------------------------------
module fps_walk #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fps_pkg::t_ctl                     i_ctl,
    output fps_pkg::t_sts                     o_sts,
    input  logic                              i_op,
    input  logic        [fps_pkg::IDX_W-1:0]  i_index,
    input  logic signed [fps_pkg::DATA_W-1:0] i_delta,
    input  logic        [fps_pkg::SIZE_W-1:0] i_active_size,
    output logic                              o_rd_en,
    output logic [$clog2(MAX_ENTRIES)-1:0]    o_rd_addr,
    input  logic        [fps_pkg::DATA_W-1:0] i_rd_data,
    output logic                              o_wr_en,
    output logic [$clog2(MAX_ENTRIES)-1:0]    o_wr_addr,
    output logic        [fps_pkg::DATA_W-1:0] o_wr_data,
    output logic        [fps_pkg::DATA_W-1:0] o_acc
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int PW = (AW + 1 > fps_pkg::SIZE_W) ? AW + 1 : fps_pkg::SIZE_W;
    localparam logic [PW-1:0] MAX_POS  = PW'(MAX_ENTRIES);
    localparam logic [AW-1:0] LAST_ROW = AW'(MAX_ENTRIES - 1);

    logic                        r_op;
    logic [PW-1:0]               r_pos;
    logic [AW-1:0]               r_prev;
    logic [fps_pkg::DATA_W-1:0]  r_delta;
    logic [fps_pkg::DATA_W-1:0]  r_acc;
    logic                        r_pend;
    logic                        n_pend;
    logic [AW-1:0]               r_clr;
    logic [AW-1:0]               n_clr;

    logic [PW-1:0]               active_ext;
    logic [PW-1:0]               bound;
    logic [PW-1:0]               lowbit;
    logic [PW-1:0]               next_pos;
    logic                        in_bound;
    logic                        cont;
    logic                        rd_issue;
    logic [fps_pkg::DATA_W-1:0]  sum;

    always_comb begin
        active_ext = PW'(i_active_size);
        bound      = (active_ext > MAX_POS) ? MAX_POS : active_ext;
        in_bound   = (r_pos < bound);
        lowbit     = r_pos & (~r_pos + PW'(1));
        next_pos   = (r_op == fps_pkg::OP_ADD) ? (r_pos + lowbit)
                                               : (r_pos & (r_pos - PW'(1)));
        // add walks stop at the bound, query walks run down to zero
        cont       = (r_pos != '0) && ((r_op == fps_pkg::OP_QUERY) || in_bound);
        rd_issue   = cont && in_bound;
        // shared adder: cell + delta on adds, cell + running sum on queries
        sum        = i_rd_data + ((r_op == fps_pkg::OP_ADD) ? r_delta : r_acc);
    end

    always_comb begin
        n_pend = i_ctl.walk ? rd_issue : 1'b0;
        n_clr  = i_ctl.clr ? (r_clr + AW'(1)) : r_clr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_clr  <= '0;
        end else begin
            r_pend <= n_pend;
            r_clr  <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op    <= i_op;
            r_pos   <= PW'(i_index);
            r_delta <= i_delta;
            r_acc   <= '0;
        end else if (i_ctl.walk) begin
            if (cont) begin
                r_pos <= next_pos;
            end
            r_prev <= r_pos[AW-1:0];
            if (r_pend && (r_op == fps_pkg::OP_QUERY)) begin
                r_acc <= sum;
            end
        end
    end

    always_comb begin
        o_rd_en   = i_ctl.walk && rd_issue;
        o_rd_addr = r_pos[AW-1:0];
        if (i_ctl.clr) begin
            o_wr_en   = 1'b1;
            o_wr_addr = r_clr;
            o_wr_data = '0;
        end else begin
            o_wr_en   = i_ctl.walk && r_pend && (r_op == fps_pkg::OP_ADD);
            o_wr_addr = r_prev;
            o_wr_data = sum;
        end
    end

    assign o_sts.cont     = cont;
    assign o_sts.clr_last = (r_clr == LAST_ROW);
    assign o_sts.is_query = (r_op == fps_pkg::OP_QUERY);
    assign o_acc          = r_acc;

`ifndef SYNTHESIS
    // the update write and the next read of a walk never share a cell
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && o_rd_en) |-> (o_wr_addr != o_rd_addr))
        else $error("walk reads and writes the same cell in one cycle");

    // read data is consumed only in the cycle after its read
    a_pend_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> $past(o_rd_en))
        else $error("pending cell data without a preceding read");
`endif

endmodule

/* rtl/fps_ctrl.sv */
// ----------------------------------------------------------------------------
// fps_ctrl
// Sequencer: clearing pass, item capture, walk steps and result hand-off.
// ----------------------------------------------------------------------------
module fps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_out_free,
    input  fps_pkg::t_sts  i_sts,
    output fps_pkg::t_ctl  o_ctl,
    output logic           o_in_ready
);

    fps_pkg::t_state r_state;
    fps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fps_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fps_pkg::ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = fps_pkg::ST_IDLE;
                end
            end
            fps_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = fps_pkg::ST_WALK;
                end
            end
            fps_pkg::ST_WALK: begin
                if (!i_sts.cont) begin
                    n_state = i_sts.is_query ? fps_pkg::ST_RESULT : fps_pkg::ST_IDLE;
                end
            end
            fps_pkg::ST_RESULT: begin
                if (i_out_free) begin
                    n_state = fps_pkg::ST_IDLE;
                end
            end
            default: n_state = fps_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        o_ctl      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fps_pkg::ST_CLEAR: begin
                o_ctl.clr = 1'b1;
            end
            fps_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_ctl.load = i_in_valid;
            end
            fps_pkg::ST_WALK: begin
                o_ctl.walk = 1'b1;
            end
            fps_pkg::ST_RESULT: begin
                o_ctl.out_load = i_out_free;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // one item at a time: capture closes the input straight away
    a_load_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> !o_in_ready)
        else $error("input still open after an item was captured");

    // the clearing pass runs once, only after reset
    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != fps_pkg::ST_CLEAR) |=> (r_state != fps_pkg::ST_CLEAR))
        else $error("clearing pass re-entered outside reset");
`endif

endmodule

/* rtl/fenwick_prefix_sum.sv */
// An item holds the block from acceptance until its walk ends (add) or until its
// sum is loaded into the output register once that is free (query). A walk visits
// at most 10 cells (the index width) at depths up to 1024. Rate is set by the table
// RAM: one cell read per cycle through its one read port. Reset: synchronous
// active-low; a clearing pass zeroes the table while input is held off;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// fenwick_prefix_sum
// Binary indexed tree engine: add items climb the tree updating cells, query
// items descend it accumulating a wrapping 32-bit prefix sum.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fps_in_if.sink      i_in,
    fps_out_if.source   o_out,
    fps_cfg_if.sink     i_cfg
);

    localparam int AW = $clog2(MAX_ENTRIES);

    fps_pkg::t_ctl               ctl;
    fps_pkg::t_sts               sts;

    logic [fps_pkg::SIZE_W-1:0]  r_active_size;
    logic                        r_out_vld;
    logic [fps_pkg::DATA_W-1:0]  r_out_sum;
    logic                        out_free;
    logic                        in_ready;

    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [fps_pkg::DATA_W-1:0]  rd_data;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [fps_pkg::DATA_W-1:0]  wr_data;
    logic [fps_pkg::DATA_W-1:0]  acc;

    // Configuration: always ready; the active size bounds both walk
    // directions and is saturated to the table depth inside the walk unit.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_size <= fps_pkg::ACTIVE_SIZE_RST;
        end else if (i_cfg.valid) begin
            r_active_size <= i_cfg.active_size;
        end
    end

    // Output register: frees the walk unit as soon as the sum is handed over.
    // It may take a new sum in the same cycle the old one is taken.
    assign out_free = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ctl.out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.out_load) begin
            r_out_sum <= acc;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.prefix_sum = r_out_sum;
    assign i_in.ready       = in_ready;

    // Sequencer: clear, idle, walk, hand over result.
    fps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_in_ready (in_ready)
    );

    // Walk unit: one cell per cycle; the read of the next cell overlaps the
    // write-back or accumulation of the previous one.
    fps_walk #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_op          (i_in.op),
        .i_index       (i_in.index),
        .i_delta       (i_in.delta),
        .i_active_size (r_active_size),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_acc         (acc)
    );

    // Tree cell store.
    fps_ram #(
        .WIDTH (fps_pkg::DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

`ifndef SYNTHESIS
    // a result is only loaded when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready) |=> !$past(ctl.out_load))
        else $error("pending result overwritten");
`endif

endmodule
